>>> design/mtfl_pkg.sv
// Shared types and constants for the move-to-front search list.
// Used by mtfl_cell, the top level and the port checker.
package mtfl_pkg;

  localparam int unsigned ValueW = 8;
  localparam int unsigned PosW   = 7;

  // Request kinds carried by req_type.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic              append;  // write value into the cell at the fill index
    logic              move;    // move-to-front step of a query
    logic              found;   // some valid cell matched the query value
    logic [ValueW-1:0] value;   // appended or queried value
  } cell_ctrl_t;

endpackage

>>> design/mtfl_cell.sv
// One cell of the list: holds a single entry, compares it with the query
// and takes its upper neighbour's entry on a move. Depends on mtfl_pkg.
module mtfl_cell #(
  parameter int unsigned DECK_DEPTH = 64,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                             clk_i,
  input  mtfl_pkg::cell_ctrl_t             ctrl_i,
  input  logic [$clog2(DECK_DEPTH+1)-1:0]  count_i,
  input  logic [mtfl_pkg::ValueW-1:0]      prev_entry_i,
  input  logic                             above_i,
  output logic [mtfl_pkg::ValueW-1:0]      entry_o,
  output logic                             above_o,
  output logic                             hit_o
);

  localparam int unsigned CntW = $clog2(DECK_DEPTH + 1);
  localparam logic [CntW-1:0] IdxC = CntW'(CELL_IDX);

  logic [mtfl_pkg::ValueW-1:0] entry_q, entry_d;
  logic                        valid;
  logic                        match;

  assign valid   = (IdxC < count_i);
  assign match   = valid && (entry_q == ctrl_i.value);
  assign above_o = above_i | match;
  assign hit_o   = match & ~above_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.append && (count_i == IdxC)) begin
      entry_d = ctrl_i.value;
    end else if (ctrl_i.move && valid && !above_i) begin
      // top takes the value; cells down to the hit shift by one
      if (CELL_IDX == 0) begin
        entry_d = ctrl_i.value;
      end else if (ctrl_i.found) begin
        entry_d = prev_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> design/move_to_front_search_list_top.sv
// Top level of the move-to-front search list: sequencer, fill count,
// output register and the chain of mtfl_cell. Depends on mtfl_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o   | req_type_i, item_value_i
//  out     | output    | out_valid_o / out_stall_i | position_o
//
// A load word is written by the cell at the fill index at the accept edge.
// A query word is registered at accept, then every cell compares in
// parallel, the first-match chain ripples down the row and the cells
// above the hit shift in the move cycle.
// The move cycle waits while a previous result is still stalled at the
// output register; in_stall_o is high from the edge after a query is
// accepted until its move completes, including any such output stall.
// Reset clears the fill count, the sequencer and the output valid; entries
// need no clearing, since only cells below the fill count are ever read.
module move_to_front_search_list_top #(
  parameter int unsigned DECK_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [mtfl_pkg::ValueW-1:0]    item_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mtfl_pkg::PosW-1:0]      position_o
);

  localparam int unsigned CntW  = $clog2(DECK_DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(DECK_DEPTH);
  localparam int unsigned PsumW = (IdxW + 1 > mtfl_pkg::PosW) ? IdxW + 1 : mtfl_pkg::PosW;

  // sequencer codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MOVE = 1'b1;

  logic                          state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [mtfl_pkg::ValueW-1:0]   query_q, query_d;
  logic                          out_valid_q, out_valid_d;
  logic [mtfl_pkg::PosW-1:0]     pos_q, pos_d;

  logic                          in_accept;
  logic                          out_free;
  logic                          move_go;
  logic                          full;
  mtfl_pkg::cell_ctrl_t          ctrl;

  logic [mtfl_pkg::ValueW-1:0]   entries [DECK_DEPTH];
  logic [DECK_DEPTH:0]           above;
  logic [DECK_DEPTH-1:0]         hit;
  logic [IdxW-1:0]               hit_idx;
  logic [PsumW-1:0]              pos_sum;

  assign in_stall_o  = (state_q == ST_MOVE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign move_go     = (state_q == ST_MOVE) && out_free;
  assign full        = (count_q == CntW'(DECK_DEPTH));
  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;

  // Broadcast control: appends come straight from the input word, moves use
  // the registered query value.
  always_comb begin
    ctrl.append = in_accept && (req_type_i == mtfl_pkg::REQ_LOAD) && !full;
    ctrl.move   = move_go;
    ctrl.found  = above[DECK_DEPTH];
    ctrl.value  = (state_q == ST_MOVE) ? query_q : item_value_i;
  end

  assign above[0] = 1'b0;

  for (genvar i = 0; i < DECK_DEPTH; i++) begin : g_cell
    logic [mtfl_pkg::ValueW-1:0] prev_entry;
    if (i == 0) begin : g_top
      assign prev_entry = query_q;
    end else begin : g_rest
      assign prev_entry = entries[i-1];
    end
    mtfl_cell #(
      .DECK_DEPTH (DECK_DEPTH),
      .CELL_IDX   (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .prev_entry_i (prev_entry),
      .above_i      (above[i]),
      .entry_o      (entries[i]),
      .above_o      (above[i+1]),
      .hit_o        (hit[i])
    );
  end

  // At most one hit bit is set, so OR the indices together; no hit gives
  // index zero, which is exactly the top position reported on a miss.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DECK_DEPTH; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
  end

  assign pos_sum = PsumW'(hit_idx) + PsumW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    query_d     = query_q;
    out_valid_d = out_valid_q;
    pos_d       = pos_q;

    if (ctrl.append) begin
      count_d = count_q + CntW'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (req_type_i == mtfl_pkg::REQ_QUERY)) begin
          query_d = item_value_i;
          state_d = ST_MOVE;
        end
        if (out_valid_q && !out_stall_i) begin
          out_valid_d = 1'b0;
        end
      end
      ST_MOVE: begin
        // hold until the output register can take the position
        if (move_go) begin
          out_valid_d = 1'b1;
          pos_d       = pos_sum[mtfl_pkg::PosW-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q <= query_d;
    pos_q   <= pos_d;
  end

endmodule

>>> design/mtfl_checker.sv
// Port checker for the move-to-front search list, bound to the top level.
// Depends on mtfl_pkg and sees the top-level ports only.
module mtfl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         req_type_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mtfl_pkg::PosW-1:0]    position_o
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o))
    else $error("stalled result word dropped or changed");

  // A query word blocks the input for its move cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == mtfl_pkg::REQ_QUERY) |=> in_stall_o)
    else $error("query word did not hold the input");

  // A load word never produces a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == mtfl_pkg::REQ_LOAD) && !out_valid_o
    |=> !out_valid_o)
    else $error("load word produced a result");

  // A fresh result appears only as a query leaves its move cycle.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> $fell(in_stall_o))
    else $error("result word without a query");

endmodule

bind move_to_front_search_list_top mtfl_checker u_mtfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .position_o  (position_o)
);

>>> sim/mtfl_port_checker.sv
`timescale 1ns / 1ps
// Port checker for the move-to-front search list: mirrors the list on every
// accepted input word and compares each accepted position. Depends on mtfl_pkg.
module mtfl_port_checker #(
  parameter int unsigned DECK_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        req_type_i,
  input  logic [mtfl_pkg::ValueW-1:0] item_value_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [mtfl_pkg::PosW-1:0]   position_i,
  output int                          mismatch_count_o,
  output int                          pending_o
);

  localparam int unsigned ValueW = mtfl_pkg::ValueW;
  localparam int unsigned PosW   = mtfl_pkg::PosW;

  logic [ValueW-1:0] deck_q [DECK_DEPTH];
  int                fill_q;
  logic [PosW-1:0]   due_positions_q [$];
  logic [PosW-1:0]   due_pos;

  // Apply one accepted word to the mirrored list; a query queues its position.
  task automatic take_word(input logic kind, input logic [ValueW-1:0] val);
    int hit;
    hit = 0;
    if (kind == mtfl_pkg::REQ_LOAD) begin
      if (fill_q < int'(DECK_DEPTH)) begin
        deck_q[fill_q] = val;
        fill_q++;
      end
    end else begin
      // scan upwards so the topmost match wins; a miss leaves the top selected
      for (int i = fill_q - 1; i >= 0; i--) begin
        if (deck_q[i] == val) hit = i;
      end
      if (fill_q != 0) begin
        for (int i = hit; i > 0; i--) deck_q[i] = deck_q[i-1];
        deck_q[0] = val;
      end
      due_positions_q = {due_positions_q, PosW'(hit + 1)};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q = 0;
      due_positions_q.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_positions_q.size() == 0) begin
          $display("%0t: position %0d arrived with none expected", $time, position_i);
          mismatch_count_o++;
        end else begin
          due_pos = due_positions_q.pop_front();
          if (position_i !== due_pos) begin
            $display("%0t: position expected %0d, got %0d", $time, due_pos, position_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_word(req_type_i, item_value_i);
      pending_o = due_positions_q.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the move-to-front search list: clock, reset, stimulus
// and verdict. Depends on mtfl_pkg, move_to_front_search_list_top and mtfl_port_checker.
module tb_top;

  localparam int unsigned ValueW = mtfl_pkg::ValueW;
  localparam int unsigned PosW   = mtfl_pkg::PosW;

  localparam int DeckDepth  = 64;
  localparam int NumWords   = 1200;
  localparam int DrainLimit = 2000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              req_type_i;
  logic [ValueW-1:0] item_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [PosW-1:0]   position_o;

  int mismatch_count;
  int pending_count;

  // Stimulus bookkeeping only: values handed to the list, so queries can hit.
  logic [ValueW-1:0] loaded_vals [$];
  int                loads_sent;
  int                counted_words;
  logic              calm;
  int                drain_cycles;

  move_to_front_search_list_top #(
    .DECK_DEPTH (DeckDepth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_o   (position_o)
  );

  mtfl_port_checker #(
    .DECK_DEPTH (DeckDepth)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .req_type_i       (req_type_i),
    .item_value_i     (item_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .position_i       (position_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run (about 0.7 ms).
  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end

  // Idle cycles before the next word on either side; none during calm stretches.
  function automatic int draw_wait();
    if (calm) return 0;
    return int'($urandom_range(0, 12));
  endfunction

  // Present one word, hold it until accepted. A zero gap keeps valid high
  // straight into the next word, so valid is never dropped and raised in one step.
  task automatic send_word(input logic kind, input logic [ValueW-1:0] val);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    item_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == mtfl_pkg::REQ_LOAD) begin
      if (loads_sent < DeckDepth) loaded_vals = {loaded_vals, val};
      loads_sent++;
    end
  endtask

  // Pick a query value: mostly a value that was loaded (hits anywhere in the
  // list), some from a tiny set (repeats near the top), the rest anything.
  function automatic logic [ValueW-1:0] pick_query();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 60 && loaded_vals.size() != 0)
      return loaded_vals[$urandom_range(0, loaded_vals.size() - 1)];
    if (roll < 80) return ValueW'($urandom_range(0, 7));
    return ValueW'($urandom_range(0, 255));
  endfunction

  // Output side: stall a random number of cycles, then take one word.
  initial begin
    int hold;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    int   phase_left;
    logic kind;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    req_type_i   <= mtfl_pkg::REQ_LOAD;
    item_value_i <= '0;
    calm          = 1'b0;
    loads_sent    = 0;
    counted_words = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: queries on an empty list, extreme values, hit at the bottom,
    // hit at the top, a miss that overwrites the top, and a duplicate entry.
    send_word(mtfl_pkg::REQ_QUERY, 8'h00);
    send_word(mtfl_pkg::REQ_QUERY, 8'hFF);
    send_word(mtfl_pkg::REQ_LOAD,  8'h00);
    send_word(mtfl_pkg::REQ_LOAD,  8'hFF);
    send_word(mtfl_pkg::REQ_LOAD,  8'h55);
    send_word(mtfl_pkg::REQ_LOAD,  8'hAA);
    send_word(mtfl_pkg::REQ_LOAD,  8'h0F);
    send_word(mtfl_pkg::REQ_QUERY, 8'h0F);
    send_word(mtfl_pkg::REQ_QUERY, 8'h0F);
    send_word(mtfl_pkg::REQ_QUERY, 8'h00);
    send_word(mtfl_pkg::REQ_QUERY, 8'hFF);
    send_word(mtfl_pkg::REQ_QUERY, 8'h5A);
    send_word(mtfl_pkg::REQ_QUERY, 8'h0F);
    send_word(mtfl_pkg::REQ_LOAD,  8'hAA);
    send_word(mtfl_pkg::REQ_QUERY, 8'hAA);
    send_word(mtfl_pkg::REQ_QUERY, 8'hAA);
    send_word(mtfl_pkg::REQ_QUERY, 8'hF0);
    send_word(mtfl_pkg::REQ_QUERY, 8'h55);

    // Random: fill the list while querying it, then keep hammering the full
    // list with queries and the odd dropped load. Phases alternate between
    // random idling and calm back-to-back stretches.
    phase_left = 0;
    while (counted_words < NumWords) begin
      if (phase_left == 0) begin
        phase_left = int'($urandom_range(20, 80));
        calm = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if (loads_sent < DeckDepth)
        kind = ($urandom_range(0, 1) == 0) ? mtfl_pkg::REQ_LOAD : mtfl_pkg::REQ_QUERY;
      else kind = ($urandom_range(0, 6) == 0) ? mtfl_pkg::REQ_LOAD : mtfl_pkg::REQ_QUERY;
      counted_words++;
      if (kind == mtfl_pkg::REQ_LOAD)
        send_word(mtfl_pkg::REQ_LOAD, ValueW'($urandom_range(0, 255)));
      else send_word(mtfl_pkg::REQ_QUERY, pick_query());
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    // let the checker book the last accepted word first
    @(posedge clk_i);

    // Drain: wait for every position still due, then a few more cycles.
    drain_cycles = 0;
    while (pending_count != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_count != 0)
      $display("%0t: %0d positions never arrived", $time, pending_count);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> move_to_front_search_list_top.f
design/mtfl_pkg.sv
design/mtfl_cell.sv
design/move_to_front_search_list_top.sv
design/mtfl_checker.sv
sim/mtfl_port_checker.sv
sim/tb_top.sv
